/* hw/rtl/decimal_text_to_integer_defines.svh */
// Assertion macros for the decimal text to integer converter.
`ifndef DECIMAL_TEXT_TO_INTEGER_DEFINES_SVH
`define DECIMAL_TEXT_TO_INTEGER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, disabled in reset.
`define DTOI_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtoi assertion failed");
// Next-cycle implication, sampled on clk, disabled in reset.
`define DTOI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtoi assertion failed");
`else
`define DTOI_ASSERT_NOW(name, ante, cons)
`define DTOI_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* hw/rtl/dtoi_pkg.sv */
// Types and constants shared by the decimal text to integer converter.
`default_nettype none
package dtoi_pkg;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SIGN    = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_TRAIL   = 3'd3,
    PH_NODIGIT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  localparam logic [1:0] CFG_ALLOW_EMPTY    = 2'd0;
  localparam logic [1:0] CFG_ALLOW_TRAILING = 2'd1;
  localparam logic [1:0] CFG_UNSIGNED_MODE  = 2'd2;
  localparam logic [1:0] CFG_WIDTH_MODE     = 2'd3;

  localparam logic [1:0] WIDTH_16 = 2'd0;
  localparam logic [1:0] WIDTH_32 = 2'd1;
  localparam logic [1:0] WIDTH_64 = 2'd2;

  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  typedef struct packed {
    phase_t      phase;
    logic        saw_any;
    logic        negative;
    logic [63:0] magnitude;
    logic        overflowed;
  } parse_state_t;

  typedef struct packed {
    logic       allow_empty;
    logic       allow_trailing;
    logic       unsigned_mode;
    logic [1:0] width_mode;
  } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/dtoi_accum.sv */
// Parse state machine and decimal digit accumulator.
`default_nettype none
module dtoi_accum
  import dtoi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   char_code,
  input  wire logic         is_end,
  output parse_state_t      state
);

  phase_t      phase, phase_next;
  logic        saw_any, saw_any_next;
  logic        negative, negative_next;
  logic [63:0] magnitude, magnitude_next;
  logic        overflowed, overflowed_next;

  logic        is_digit, is_space, is_sign;
  logic [3:0]  digit;
  logic [67:0] times_ten;
  logic        take_digit;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_space = (char_code == CHAR_SPACE) ||
                    ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
  assign is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
  assign digit    = 4'(char_code - CHAR_ZERO);

  // m*10 + d as shift-add; anything above bit 63 is overflow
  assign times_ten = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} +
                     {64'd0, digit};

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_end) begin
      phase_next = PH_START;
    end else begin
      case (phase)
        PH_START: begin
          if (is_space) phase_next = PH_START;
          else if (is_sign) phase_next = PH_SIGN;
          else if (is_digit) phase_next = PH_DIGITS;
          else phase_next = PH_NODIGIT;
        end
        PH_SIGN: begin
          phase_next = is_digit ? PH_DIGITS : PH_NODIGIT;
        end
        PH_DIGITS: begin
          if (!is_digit) phase_next = PH_TRAIL;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath
  always_comb begin
    take_digit      = 1'b0;
    saw_any_next    = saw_any;
    negative_next   = negative;
    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    case (phase)
      PH_START:  take_digit = is_digit && !is_space;
      PH_SIGN:   take_digit = is_digit;
      PH_DIGITS: take_digit = is_digit;
      default:   take_digit = 1'b0;
    endcase
    if (is_end) begin
      saw_any_next    = 1'b0;
      negative_next   = 1'b0;
      magnitude_next  = '0;
      overflowed_next = 1'b0;
    end else begin
      saw_any_next = 1'b1;
      if ((phase == PH_START) && !is_space && is_sign) begin
        negative_next = (char_code == CHAR_MINUS);
      end
      if (take_digit && !overflowed) begin
        if (times_ten[67:64] != 4'd0) begin
          overflowed_next = 1'b1;
          magnitude_next  = '1;
        end else begin
          magnitude_next = times_ten[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      saw_any    <= 1'b0;
      negative   <= 1'b0;
      magnitude  <= '0;
      overflowed <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      saw_any    <= saw_any_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      overflowed <= overflowed_next;
    end
  end

  always_comb begin
    state.phase      = phase;
    state.saw_any    = saw_any;
    state.negative   = negative;
    state.magnitude  = magnitude;
    state.overflowed = overflowed;
  end

endmodule
`default_nettype wire

/* hw/rtl/dtoi_finish.sv */
// End-of-string checks: empty input, missing digits, range, trailing text, narrowing, final value.
`default_nettype none
module dtoi_finish
  import dtoi_pkg::*;
(
  input  wire parse_state_t  state,
  input  wire cfg_t          cfg,
  output status_t            status,
  output logic [63:0]        value
);

  logic [63:0] v;
  logic        range_64;
  logic        narrow_bad;
  logic        had_digits;

  assign had_digits = (state.phase == PH_DIGITS) || (state.phase == PH_TRAIL);
  assign v = state.negative ? (64'd0 - state.magnitude) : state.magnitude;

  // signed limit is 2^63-1, or 2^63 after a minus
  always_comb begin
    if (cfg.unsigned_mode) begin
      range_64 = state.overflowed;
    end else if (state.negative) begin
      range_64 = state.overflowed ||
                 (state.magnitude[63] && (state.magnitude[62:0] != 63'd0));
    end else begin
      range_64 = state.overflowed || state.magnitude[63];
    end
  end

  always_comb begin
    case (cfg.width_mode)
      WIDTH_16: begin
        if (cfg.unsigned_mode) narrow_bad = (v[63:16] != 48'd0);
        else narrow_bad = (v[63:15] != 49'd0) && (v[63:15] != '1);
      end
      WIDTH_32: begin
        if (cfg.unsigned_mode) narrow_bad = (v[63:32] != 32'd0);
        else narrow_bad = (v[63:31] != 33'd0) && (v[63:31] != '1);
      end
      default: narrow_bad = 1'b0;
    endcase
  end

  always_comb begin
    value = '0;
    if (!state.saw_any) begin
      status = cfg.allow_empty ? ST_OK : ST_INVALID;
    end else if (!had_digits) begin
      status = ST_INVALID;
    end else if (range_64) begin
      status = ST_RANGE;
    end else if ((state.phase == PH_TRAIL) && !cfg.allow_trailing) begin
      status = ST_INVALID;
    end else if (narrow_bad) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
      value  = v;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/decimal_text_to_integer.sv */
// Top level of the decimal text to integer converter.
// Usage:
//   Requests arrive on req_valid/req_ready, one character byte (char_code)
//   each, and a request with is_end high closes the string. Leading
//   whitespace, an optional sign and decimal digits are parsed with strtol
//   or strtoul base-10 rules. Only the end request makes a result, given on
//   res_valid/res_ready as status and value.
//   Timing: a request is taken into the input register and is processed
//   when it leaves it; the result of an end request is loaded into the
//   result register, which drives res_valid, as that request leaves.
//   Throughput: one request per cycle, set by the digit update (shift-add
//   times ten with a 64-bit overflow check) while no end request stalls.
//   Stall: while a result waits, character requests keep flowing; an end
//   request halts in the input register and req_ready drops until the
//   result is taken.
//   Reset: clears the parse state, the pipeline valids and the config
//   registers (allow_empty 0, allow_trailing 0, unsigned_mode 0,
//   width_mode sixty-four bits). Config writes land at once on cfg_we.
`default_nettype none
`include "decimal_text_to_integer_defines.svh"
module decimal_text_to_integer
  import dtoi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        is_end,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       status,
  output logic [63:0]      value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data
);

  cfg_t         cfg;
  parse_state_t state;
  status_t      fin_status;
  logic [63:0]  fin_value;

  // input register
  logic       q_valid;
  logic [7:0] q_char;
  logic       q_end;
  logic       q_fire;
  logic       res_load;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.allow_empty    <= 1'b0;
      cfg.allow_trailing <= 1'b0;
      cfg.unsigned_mode  <= 1'b0;
      cfg.width_mode     <= WIDTH_64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALLOW_EMPTY:    cfg.allow_empty    <= cfg_data[0];
        CFG_ALLOW_TRAILING: cfg.allow_trailing <= cfg_data[0];
        CFG_UNSIGNED_MODE:  cfg.unsigned_mode  <= cfg_data[0];
        CFG_WIDTH_MODE:     cfg.width_mode     <= cfg_data;
        default:            cfg.width_mode     <= cfg.width_mode;
      endcase
    end
  end

  // A character always advances; an end request needs the result slot
  // empty or being drained this cycle.
  assign q_fire    = q_valid && (!q_end || !res_valid || res_ready);
  assign req_ready = !q_valid || q_fire;
  assign res_load  = q_fire && q_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req_ready) begin
      q_valid <= req_valid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      q_char <= char_code;
      q_end  <= is_end;
    end
  end

  dtoi_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (q_fire),
    .char_code (q_char),
    .is_end    (q_end),
    .state     (state)
  );

  dtoi_finish u_finish (
    .state  (state),
    .cfg    (cfg),
    .status (fin_status),
    .value  (fin_value)
  );

  // result register: load on end, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= fin_status;
      value  <= fin_value;
    end
  end

  // error results carry a zero value
  `DTOI_ASSERT_NOW(a_err_zero, res_valid && (status != ST_OK), value == 64'd0)
  // an end request stuck behind a held result blocks the input
  `DTOI_ASSERT_NOW(a_end_stall, q_valid && q_end && res_valid && !res_ready, !req_ready)
  // closing a string returns the parser to its start
  `DTOI_ASSERT_NEXT(a_end_clears, res_load,
                    (state.phase == PH_START) && !state.saw_any && (state.magnitude == 64'd0))
  // every end processed produces a visible result next cycle
  `DTOI_ASSERT_NEXT(a_end_result, res_load, res_valid)

endmodule
`default_nettype wire
